// ----- design/url_percent_decoder_macros.svh -----
// Assertion macros for the URL percent decoder.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define UPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UPD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define UPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define UPD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- design/upd_pkg.sv -----
// Shared types, constants and helpers for the URL percent decoder.
// No dependencies; used by every module of the block.
package upd_pkg;

  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic REG_OUT_CAPACITY = 1'b0;
  localparam logic REG_PLUS_AS_SPACE = 1'b1;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0] cnt;
    logic is_end;
  } upd_entry_t;

  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- design/upd_front.sv -----
// Front end of the URL percent decoder: accepts text bytes and tracks escapes.
// Depends on upd_pkg; pushes the bytes each item yields into the queue.
module upd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               plus_as_space,
  input  logic               q_full,
  output logic               push,
  output upd_pkg::upd_entry_t push_entry
);
  import upd_pkg::*;

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_PCT,
    HELD_DIGIT
  } held_t;

  held_t held;
  held_t held_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;
  logic accept;
  logic fresh_emit;
  logic [7:0] fresh_val;
  held_t fresh_held;
  logic [4:0] lo_nib;
  logic [4:0] hi_nib;
  upd_entry_t ent;

  assign in_stall = q_full;
  assign accept = in_valid && !in_stall;
  assign lo_nib = hex_nibble(in_byte);
  assign hi_nib = hex_nibble(held_digit);
  assign fresh_emit = (in_byte != CH_PERCENT);
  assign fresh_val = (plus_as_space && in_byte == CH_PLUS) ? CH_SPACE : in_byte;
  assign fresh_held = fresh_emit ? HELD_NONE : HELD_PCT;

  always_comb begin
    ent = '0;
    held_next = held;
    held_digit_next = held_digit;
    if (in_byte == CH_NUL) begin
      ent.is_end = 1'b1;
      ent.bytes[0] = CH_PERCENT;
      ent.bytes[1] = held_digit;
      case (held)
        HELD_PCT: ent.cnt = 2'd1;
        HELD_DIGIT: ent.cnt = 2'd2;
        default: ent.cnt = 2'd0;
      endcase
      held_next = HELD_NONE;
      held_digit_next = '0;
    end else begin
      case (held)
        HELD_NONE: begin
          ent.bytes[0] = fresh_val;
          ent.cnt = fresh_emit ? 2'd1 : 2'd0;
          held_next = fresh_held;
        end
        HELD_PCT: begin
          if (lo_nib[4]) begin
            held_digit_next = in_byte;
            held_next = HELD_DIGIT;
          end else begin
            ent.bytes[0] = CH_PERCENT;
            ent.bytes[1] = fresh_val;
            ent.cnt = fresh_emit ? 2'd2 : 2'd1;
            held_next = fresh_held;
          end
        end
        HELD_DIGIT: begin
          held_digit_next = '0;
          if (lo_nib[4] && hi_nib[4]) begin
            ent.bytes[0] = {hi_nib[3:0], lo_nib[3:0]};
            ent.cnt = 2'd1;
            held_next = HELD_NONE;
          end else begin
            ent.bytes[0] = CH_PERCENT;
            ent.bytes[1] = held_digit;
            ent.bytes[2] = fresh_val;
            ent.cnt = fresh_emit ? 2'd3 : 2'd2;
            held_next = fresh_held;
          end
        end
        default: held_next = HELD_NONE;
      endcase
    end
  end

  assign push = accept && (ent.cnt != 2'd0 || ent.is_end);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= HELD_NONE;
      held_digit <= '0;
    end else if (accept) begin
      held <= held_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

// ----- design/upd_queue.sv -----
// Short queue between the front end and the back end of the decoder.
// Depends on upd_pkg for the entry type and depth.
module upd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  upd_pkg::upd_entry_t push_entry,
  input  logic               pop,
  output upd_pkg::upd_entry_t head,
  output logic               head_valid,
  output logic               full
);
  import upd_pkg::*;

  upd_entry_t slots [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0] count;
  logic do_pop;
  logic do_push;

  assign do_pop = pop && head_valid;
  assign do_push = push && !full;
  assign head_valid = (count != '0);
  assign full = (count == (QAw+1)'(QDepth));
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAw'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAw'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + (QAw+1)'(1);
        2'b01: count <= count - (QAw+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/upd_back.sv -----
// Back end of the decoder: applies the capacity limit and emits results.
// Depends on upd_pkg; drains the queue and drives the output register.
module upd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        out_capacity,
  input  upd_pkg::upd_entry_t head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               text_end,
  output logic [15:0]        total_length,
  output logic               last_of_run
);
  import upd_pkg::*;

  logic [15:0] emitted;
  logic [15:0] emitted_next;
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic load_ok;
  logic produce;
  logic pass;
  logic pass2;
  logic [7:0] r_byte;
  logic r_bv;
  logic r_end;
  logic [15:0] r_total;
  logic r_last;

  assign load_ok = !out_valid || !out_stall;
  assign pass = ({1'b0, emitted} + 17'd1) < {1'b0, out_capacity};
  assign pass2 = ({1'b0, emitted} + 17'd2) < {1'b0, out_capacity};

  always_comb begin
    pop = 1'b0;
    produce = 1'b0;
    emitted_next = emitted;
    idx_next = idx;
    r_byte = '0;
    r_bv = 1'b0;
    r_end = 1'b0;
    r_total = emitted;
    r_last = 1'b0;
    if (head_valid && load_ok) begin
      if (idx < head.cnt && pass) begin
        produce = 1'b1;
        r_byte = head.bytes[idx];
        r_bv = 1'b1;
        r_end = head.is_end;
        r_total = emitted + 16'd1;
        emitted_next = emitted + 16'd1;
        r_last = !head.is_end && ((idx == head.cnt - 2'd1) || !pass2);
        if (r_last) begin
          pop = 1'b1;
          idx_next = '0;
        end else begin
          idx_next = idx + 2'd1;
        end
      end else if (idx < head.cnt && !head.is_end) begin
        pop = 1'b1;
        idx_next = '0;
      end else begin
        produce = 1'b1;
        r_end = 1'b1;
        r_last = 1'b1;
        emitted_next = '0;
        pop = 1'b1;
        idx_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted <= '0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      emitted <= emitted_next;
      idx <= idx_next;
      if (load_ok) begin
        out_valid <= produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && produce) begin
      out_byte <= r_byte;
      byte_valid <= r_bv;
      text_end <= r_end;
      total_length <= r_total;
      last_of_run <= r_last;
    end
  end

endmodule

// ----- design/url_percent_decoder.sv -----
// Top level of the streaming URL percent decoder.
// Depends on upd_pkg, upd_front, upd_queue, upd_back and the assertion macros.
//
// Text bytes enter on the in channel (in_valid, in_stall, in_byte), one per
// transaction; a zero byte ends the text. Results leave on the out channel
// (out_valid, out_stall and the result fields), one per transaction, with
// last_of_run marking the final result of each input byte.
// The front end takes a byte every cycle while the four-entry queue has room.
// A byte's results are written into the queue, then loaded into the output
// register before they are presented on the out channel. The back end emits
// one result per cycle while out_stall is low; a byte that yields two or
// three results (broken escapes, flushes at the end of text) holds the queue
// head until all are out, and one whose output is dropped at the capacity
// limit is popped with no result. When out_stall is high the output register
// holds its result, the queue fills, and in_stall rises once it is full.
// Reset clears the escape state, the queue, the byte count, out_capacity
// to 256 and plus_as_space to 0. The configuration port is always ready.
module url_percent_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        text_end,
  output logic [15:0] total_length,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import upd_pkg::*;

  `include "url_percent_decoder_macros.svh"

  logic [15:0] out_capacity;
  logic plus_as_space;
  logic push;
  upd_entry_t push_entry;
  logic pop;
  upd_entry_t head;
  logic head_valid;
  logic q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAPACITY_RESET;
      plus_as_space <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUT_CAPACITY: out_capacity <= cfg_data;
        REG_PLUS_AS_SPACE: plus_as_space <= cfg_data[0];
        default: out_capacity <= out_capacity;
      endcase
    end
  end

  upd_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .plus_as_space(plus_as_space),
    .q_full(q_full),
    .push(push),
    .push_entry(push_entry)
  );

  upd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head(head),
    .head_valid(head_valid),
    .full(q_full)
  );

  upd_back u_back (
    .clk(clk),
    .rst(rst),
    .out_capacity(out_capacity),
    .head(head),
    .head_valid(head_valid),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .text_end(text_end),
    .total_length(total_length),
    .last_of_run(last_of_run)
  );

  `UPD_ASSERT_IMPL(a_end_marker, clk, rst, out_valid && !byte_valid,
                   text_end && last_of_run && out_byte == 8'd0, "End result is malformed.")
  `UPD_ASSERT_IMPL(a_byte_counted, clk, rst, out_valid && byte_valid,
                   total_length != 16'd0, "Byte result carries a zero length.")
  `UPD_ASSERT_NEVER(a_push_when_full, clk, rst, push && q_full, "Queue pushed while full.")

endmodule

// ----- test/tb_url_percent_decoder.sv -----
// Self-checking testbench for url_percent_decoder: streams texts through the
// decoder under random idling and checks every result against a local decoder.
// Depends on upd_pkg and the url_percent_decoder RTL.
module tb_url_percent_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        text_end;
    logic [15:0] total_length;
    logic        last_of_run;
  } dec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        text_end;
  logic [15:0] total_length;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_OUT_CAPACITY;
  logic [15:0] cfg_data = 16'h0000;

  url_percent_decoder uut (.*);

  always #5 clk = ~clk;

  // Decoder state and register copies.
  logic [1:0]  esc_state = 2'd0;
  logic [7:0]  esc_digit = 8'h00;
  int          text_len = 0;
  int          cap_reg = int'(CAPACITY_RESET);
  logic        plus_reg = 1'b0;

  dec_result_t run_q[$];
  dec_result_t expect_q[$];
  logic [7:0]  text_q[$];
  int          n_queued = 0;
  int          n_accepted = 0;
  int          fail_count = 0;
  logic        idle_on = 1'b1;
  int          gap_left = 0;
  int          stall_left = 0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic put_byte(input logic [7:0] d, input logic endf);
    if (text_len + 1 < cap_reg) begin
      text_len++;
      run_q.push_back('{d, 1'b1, endf, 16'(text_len), 1'b0});
    end
  endtask

  task automatic take_fresh(input logic [7:0] d);
    if (d == CH_PERCENT) begin
      esc_state = 2'd1;
    end else if (plus_reg && d == CH_PLUS) begin
      put_byte(CH_SPACE, 1'b0);
    end else begin
      put_byte(d, 1'b0);
    end
  endtask

  task automatic decode_byte(input logic [7:0] d);
    int lo;
    int hi;
    logic [7:0] held;
    lo = hex_value(d);
    hi = hex_value(esc_digit);
    held = esc_digit;
    run_q.delete();
    if (d == CH_NUL) begin
      if (esc_state >= 2'd1) put_byte(CH_PERCENT, 1'b1);
      if (esc_state >= 2'd2) put_byte(esc_digit, 1'b1);
      run_q.push_back('{8'h00, 1'b0, 1'b1, 16'(text_len), 1'b0});
      esc_state = 2'd0;
      esc_digit = 8'h00;
      text_len = 0;
    end else if (esc_state == 2'd0) begin
      take_fresh(d);
    end else if (esc_state == 2'd1) begin
      if (lo >= 0) begin
        esc_digit = d;
        esc_state = 2'd2;
      end else begin
        esc_state = 2'd0;
        put_byte(CH_PERCENT, 1'b0);
        take_fresh(d);
      end
    end else begin
      esc_state = 2'd0;
      esc_digit = 8'h00;
      if (lo >= 0 && hi >= 0) begin
        put_byte({hi[3:0], lo[3:0]}, 1'b0);
      end else begin
        put_byte(CH_PERCENT, 1'b0);
        put_byte(held, 1'b0);
        take_fresh(d);
      end
    end
    if (run_q.size() > 0) run_q[$].last_of_run = 1'b1;
    foreach (run_q[i]) expect_q.push_back(run_q[i]);
  endtask

  // Input driver: one byte per transaction, with a drawn gap after each.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_byte <= text_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_on ? $urandom_range(0, 4) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result monitor: checks each transaction, then draws a stall.
  always @(posedge clk) begin
    dec_result_t exp_r;
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count++;
        end else begin
          exp_r = expect_q.pop_front();
          check_field("out_byte", exp_r.out_byte, out_byte);
          check_field("byte_valid", exp_r.byte_valid, byte_valid);
          check_field("text_end", exp_r.text_end, text_end);
          check_field("total_length", exp_r.total_length, total_length);
          check_field("last_of_run", exp_r.last_of_run, last_of_run);
        end
        n = idle_on ? $urandom_range(0, 4) : 0;
        stall_left <= n;
        out_stall <= (n > 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    text_q.push_back(c);
    n_queued++;
  endtask

  task automatic queue_bytes(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(int'("0") + v);
    return 8'(($urandom_range(0, 1) ? int'("a") : int'("A")) + v - 10);
  endfunction

  task automatic queue_text(input int tokens);
    for (int i = 0; i < tokens; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_byte(CH_PERCENT);
          send_byte(hex_char());
          send_byte(hex_char());
        end
        4, 5: send_byte(8'($urandom_range(33, 126)));
        6: send_byte(CH_PLUS);
        7: begin
          send_byte(CH_PERCENT);
          if ($urandom_range(0, 1)) send_byte(hex_char());
        end
        default: send_byte(8'($urandom_range(1, 255)));
      endcase
    end
    send_byte(CH_NUL);
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_OUT_CAPACITY) cap_reg = int'(val);
    else plus_reg = val[0];
  endtask

  initial begin
    logic [7:0]  seq[$];
    logic [15:0] caps[8];
    logic        pluses[8];
    int          phase_start;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    seq = '{CH_PERCENT, "4", "1", CH_PERCENT, "G", CH_PERCENT, "4", CH_PERCENT, "2", "b",
            CH_PLUS, 8'hFF, CH_PERCENT, "0", "0", CH_PERCENT, "A", CH_NUL, CH_NUL};
    queue_bytes(seq);
    wait_idle();

    write_reg(REG_PLUS_AS_SPACE, 16'd1);
    seq = '{CH_PLUS, CH_PERCENT, CH_PLUS, CH_PERCENT, CH_NUL};
    queue_bytes(seq);
    wait_idle();

    // The plus mode is switched off in the middle of a held escape.
    seq = '{CH_PERCENT, "2"};
    queue_bytes(seq);
    wait_idle();
    write_reg(REG_PLUS_AS_SPACE, 16'd0);
    seq = '{CH_PLUS, CH_NUL};
    queue_bytes(seq);
    wait_idle();

    caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'($urandom_range(4, 24)), 16'hFFFF,
             CAPACITY_RESET};
    pluses = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b0,
               1'($urandom_range(0, 1))};
    for (int p = 0; p < 8; p++) begin
      idle_on = (p % 3 != 2);
      write_reg(REG_OUT_CAPACITY, caps[p]);
      write_reg(REG_PLUS_AS_SPACE, {15'd0, pluses[p]});
      phase_start = n_queued;
      while (n_queued - phase_start < 27) queue_text($urandom_range(0, 12));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
